@@ hw/rtl/indexed_list_store_defines.svh @@
// ----------------------------------------------------------------------------
// indexed_list_store_defines
// Assertion macros shared by the list store checkers. Each macro expects a
// clock named clock and an active-high synchronous reset named reset in scope.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Types and fixed field widths of the indexed list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

   localparam int OPCODE_W   = 2;
   localparam int POSITION_W = 6;
   localparam int ITEM_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD_WAIT,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [ITEM_W-1:0]   data_out;
      logic [COUNT_W-1:0]  element_count;
      logic                appended_when_full;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/ils_req_if.sv @@
// ----------------------------------------------------------------------------
// ils_req_if
// Request channel: one list operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_req_if;
   logic                            valid;
   logic                            ready;
   logic [ils_pkg::OPCODE_W-1:0]    opcode;
   logic [ils_pkg::POSITION_W-1:0]  position;
   logic [ils_pkg::ITEM_W-1:0]      item_value;

   modport source (output valid, opcode, position, item_value, input ready);
   modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ils_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ils_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ils_pkg::STATUS_W-1:0]    status;
   logic [ils_pkg::ITEM_W-1:0]      data_out;
   logic [ils_pkg::COUNT_W-1:0]     element_count;
   logic                            appended_when_full;

   modport source (output valid, status, data_out, element_count, appended_when_full,
                   input ready);
   modport sink   (input valid, status, data_out, element_count, appended_when_full,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ils_ram.sv @@
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer of the list store: decodes an operation, keeps the count and
// walks the entry RAM one entry per cycle for insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ils_pkg::OPCODE_W-1:0]      opcode,
   input  wire logic [ils_pkg::POSITION_W-1:0]    position,
   input  wire logic [ils_pkg::ITEM_W-1:0]        item_value,
   input  wire logic                              rsp_free,
   output logic                                   result_load,
   output ils_pkg::result_type                    result,
   output logic                                   rd_en,
   output logic      [AW-1:0]                     rd_addr,
   input  wire logic [DATA_WIDTH-1:0]             rd_data,
   output logic                                   wr_en,
   output logic      [AW-1:0]                     wr_addr,
   output logic      [DATA_WIDTH-1:0]             wr_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ils_pkg::POSITION_W) ? CNT_W : ils_pkg::POSITION_W;

   ils_pkg::state_type  state_ff, state_in;
   ils_pkg::op_type     op_ff, op_in;
   ils_pkg::status_type status_ff, status_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]         word_ff, word_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [AW-1:0]                 src_ff, src_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 last_ff, last_in;
   logic [ils_pkg::ITEM_W-1:0]    data_ff, data_in;
   logic                          af_ff, af_in;

   ils_pkg::op_type     req_op;
   logic                accept;
   logic                full;
   logic                pos_bad;
   logic                rem_done;
   logic                shift_end;
   logic [63:0]         item_wide;
   logic [63:0]         rd_wide;
   logic [DATA_WIDTH-1:0] req_word;

   assign req_op    = ils_pkg::op_type'(opcode);
   assign accept    = req_valid && (state_ff == ils_pkg::S_IDLE);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_bad   = (CMP_W'(position) >= CMP_W'(count_ff));
   assign rem_done  = (rem_ff == '0);
   assign shift_end = rem_done && !pend_ff;
   assign item_wide = 64'(item_value);
   assign req_word  = item_wide[DATA_WIDTH-1:0];
   assign rd_wide   = 64'(rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ils_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  ils_pkg::OP_APPEND: state_in = ils_pkg::S_RESP;
                  ils_pkg::OP_INSERT: begin
                     state_in = (pos_bad || full) ? ils_pkg::S_RESP : ils_pkg::S_SHIFT;
                  end
                  ils_pkg::OP_READ,
                  ils_pkg::OP_REMOVE: begin
                     state_in = pos_bad ? ils_pkg::S_RESP : ils_pkg::S_RD_WAIT;
                  end
               endcase
            end
         end
         ils_pkg::S_RD_WAIT: begin
            state_in = (op_ff == ils_pkg::OP_REMOVE) ? ils_pkg::S_SHIFT : ils_pkg::S_RESP;
         end
         ils_pkg::S_SHIFT: begin
            if (shift_end) begin
               state_in = ils_pkg::S_RESP;
            end
         end
         ils_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = ils_pkg::S_IDLE;
            end
         end
      endcase
   end

   // RAM ports and handshake outputs
   always_comb begin
      req_ready   = 1'b0;
      result_load = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = src_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(count_ff);
      wr_data     = req_word;
      unique case (state_ff)
         ils_pkg::S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = AW'(position);
            rd_en     = accept && !pos_bad &&
                        ((req_op == ils_pkg::OP_READ) || (req_op == ils_pkg::OP_REMOVE));
            wr_en     = accept && (req_op == ils_pkg::OP_APPEND) && !full;
         end
         ils_pkg::S_RD_WAIT: begin
         end
         ils_pkg::S_SHIFT: begin
            rd_en = !rem_done;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = (op_ff == ils_pkg::OP_INSERT) ? last_ff + 1'b1 : last_ff - 1'b1;
               wr_data = rd_data;
            end else if (rem_done && (op_ff == ils_pkg::OP_INSERT)) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = word_ff;
            end
         end
         ils_pkg::S_RESP: begin
            result_load = rsp_free;
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      word_in   = word_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      rem_in    = rem_ff;
      pend_in   = 1'b0;
      last_in   = last_ff;
      status_in = status_ff;
      data_in   = data_ff;
      af_in     = af_ff;
      unique case (state_ff)
         ils_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               pos_in    = AW'(position);
               word_in   = req_word;
               status_in = ils_pkg::STATUS_DONE;
               data_in   = '0;
               af_in     = 1'b0;
               if (req_op == ils_pkg::OP_APPEND) begin
                  if (full) begin
                     status_in = ils_pkg::STATUS_FULL;
                     af_in     = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (pos_bad) begin
                  status_in = ils_pkg::STATUS_RANGE;
               end else if (req_op == ils_pkg::OP_INSERT) begin
                  if (full) begin
                     status_in = ils_pkg::STATUS_FULL;
                  end else begin
                     // walk down from the last entry to the insert position
                     src_in = AW'(count_ff - 1'b1);
                     rem_in = count_ff - CNT_W'(position);
                  end
               end
            end
         end
         ils_pkg::S_RD_WAIT: begin
            data_in = rd_wide[ils_pkg::ITEM_W-1:0];
            // walk up from the entry after the removed one
            src_in  = pos_ff + 1'b1;
            rem_in  = count_ff - CNT_W'(pos_ff) - 1'b1;
         end
         ils_pkg::S_SHIFT: begin
            if (!rem_done) begin
               src_in  = (op_ff == ils_pkg::OP_INSERT) ? src_ff - 1'b1 : src_ff + 1'b1;
               rem_in  = rem_ff - 1'b1;
               pend_in = 1'b1;
               last_in = src_ff;
            end else if (!pend_ff) begin
               count_in = (op_ff == ils_pkg::OP_INSERT) ? count_ff + 1'b1 : count_ff - 1'b1;
            end
         end
         ils_pkg::S_RESP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ils_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      word_ff   <= word_in;
      src_ff    <= src_in;
      rem_ff    <= rem_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      af_ff     <= af_in;
   end

   assign result.status             = status_ff;
   assign result.data_out           = data_ff;
   assign result.element_count      = ils_pkg::COUNT_W'(count_ff);
   assign result.appended_when_full = af_ff;

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_store.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of data words in a fixed-capacity RAM with append, insert,
// read and remove by position.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and answers each with
// exactly one response transaction. Append and any refused operation go
// from acceptance straight to the response state, a read passes through a
// RAM wait state first, and insert or remove walk the entries behind the
// position (remove after its RAM wait state): the entries move one place
// per cycle, bounded by the one read and one write port of the entry RAM. A
// finished response sits in an output register, so the sequencer frees
// itself as soon as the response is loaded there. The entry RAM needs no
// clearing after reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   ils_req_if.sink   req_ch,
   ils_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(CAPACITY);

   // entry RAM ports
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // response hand-off from the sequencer
   ils_pkg::result_type result;
   logic                result_load;
   logic                rsp_free;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   ils_pkg::result_type rsp_data_ff, rsp_data_in;

   ils_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ils_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ils_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ils_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .opcode      (req_ch.opcode),
      .position    (req_ch.position),
      .item_value  (req_ch.item_value),
      .rsp_free    (rsp_free),
      .result_load (result_load),
      .result      (result),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // The slot is free when empty or when its transaction completes now.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_load) begin
         // load a fresh response
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         // drop the delivered response
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = rsp_data_ff.status;
   assign rsp_ch.data_out           = rsp_data_ff.data_out;
   assign rsp_ch.element_count      = rsp_data_ff.element_count;
   assign rsp_ch.appended_when_full = rsp_data_ff.appended_when_full;

endmodule

`default_nettype wire

@@ hw/rtl/ils_checker.sv @@
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the list store, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_store_defines.svh"

module ils_checker #(
   parameter int CAPACITY = 64
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [ils_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [ils_pkg::ITEM_W-1:0]       rsp_data_out,
   input wire logic [ils_pkg::COUNT_W-1:0]      rsp_element_count,
   input wire logic                             rsp_appended_when_full
);

   `ILS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_element_count), "response changed while stalled")

   `ILS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

   `ILS_ASSERT_NOW(a_full_flag, rsp_valid && rsp_appended_when_full, rsp_status == ils_pkg::STATUS_FULL, "full append flag without full status")

   `ILS_ASSERT_NOW(a_full_count, rsp_valid && (rsp_status == ils_pkg::STATUS_FULL), rsp_element_count == ils_pkg::COUNT_W'(CAPACITY), "full status below capacity")

   `ILS_ASSERT_NOW(a_refused_zero, rsp_valid && (rsp_status != ils_pkg::STATUS_DONE), rsp_data_out == '0, "refused operation returned data")

endmodule

bind indexed_list_store ils_checker #(
   .CAPACITY (CAPACITY)
) u_ils_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_ch.valid),
   .req_ready              (req_ch.ready),
   .rsp_valid              (rsp_ch.valid),
   .rsp_ready              (rsp_ch.ready),
   .rsp_status             (rsp_ch.status),
   .rsp_data_out           (rsp_ch.data_out),
   .rsp_element_count      (rsp_ch.element_count),
   .rsp_appended_when_full (rsp_ch.appended_when_full)
);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_list_store. A queued driver feeds list
// operations (directed corner cases, then random runs that grow, shrink and
// churn the list through full and empty). A monitor keeps a shadow copy of the
// list, predicts each response at request acceptance and checks the responses
// in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ils_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_OPS   = 400;

   // random traffic moods
   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIXED  = 2;

   typedef struct {
      op_type             op;
      logic [POSITION_W-1:0] pos;
      logic [ITEM_W-1:0]  value;
   } list_op_type;

   logic clock;
   logic reset;

   ils_req_if req_ch ();
   ils_rsp_if rsp_ch ();

   indexed_list_store #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (ITEM_W)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Operations waiting to be driven, filled once at time zero.
   list_op_type pending_ops[$];
   list_op_type next_op;
   int          total_ops;
   int          issued_ops;
   int          gen_len;

   // Shadow list and the responses it predicts, oldest first.
   logic [ITEM_W-1:0] list_words [LIST_DEPTH];
   int                list_len;
   result_type        awaited_results[$];

   int error_count;
   int cycle_count;

   always #6 clock = ~clock;

   // Idle and stall percentages by traffic phase: sender light / receiver
   // heavy, then the reverse, then full throughput.
   function automatic int send_idle_pct(int issued);
      if (issued < total_ops / 3) return 17;
      if (issued < 2 * total_ops / 3) return 77;
      return 0;
   endfunction

   function automatic int recv_stall_pct(int issued);
      if (issued < total_ops / 3) return 77;
      if (issued < 2 * total_ops / 3) return 17;
      return 0;
   endfunction

   // Queue one operation and track the list length it leaves behind, so
   // random positions can be aimed inside the list.
   task automatic add_op(op_type op, int pos, logic [ITEM_W-1:0] value);
      list_op_type item;
      item.op    = op;
      item.pos   = pos[POSITION_W-1:0];
      item.value = value;
      pending_ops.push_back(item);
      case (op)
         OP_APPEND: begin
            if (gen_len < LIST_DEPTH) gen_len++;
         end
         OP_INSERT: begin
            if (pos < gen_len && gen_len < LIST_DEPTH) gen_len++;
         end
         OP_REMOVE: begin
            if (pos < gen_len) gen_len--;
         end
         default: ;
      endcase
   endtask

   function automatic logic [ITEM_W-1:0] random_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return $urandom;
   endfunction

   // Mostly aim inside the current list; sometimes anywhere in the index range.
   function automatic int random_pos();
      if (gen_len > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, gen_len - 1);
      return $urandom_range(0, LIST_DEPTH - 1);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present the next operation whenever the channel is free; drop
   // valid on idle cycles.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(issued_ops)) begin
            next_op = pending_ops.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= next_op.op;
            req_ch.position   <= next_op.pos;
            req_ch.item_value <= next_op.value;
            issued_ops        <= issued_ops + 1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall the response channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(issued_ops));
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each response transaction against the oldest prediction,
   // then update the shadow list for each accepted request transaction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin : check_response
            result_type want;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response status=%0d data=%h count=%0d full=%0b",
                        $time, rsp_ch.status, rsp_ch.data_out, rsp_ch.element_count,
                        rsp_ch.appended_when_full);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.data_out !== want.data_out) begin
                  $display("%0t: data_out expected %h actual %h",
                           $time, want.data_out, rsp_ch.data_out);
                  error_count++;
               end
               if (rsp_ch.element_count !== want.element_count) begin
                  $display("%0t: element_count expected %0d actual %0d",
                           $time, want.element_count, rsp_ch.element_count);
                  error_count++;
               end
               if (rsp_ch.appended_when_full !== want.appended_when_full) begin
                  $display("%0t: appended_when_full expected %0b actual %0b",
                           $time, want.appended_when_full, rsp_ch.appended_when_full);
                  error_count++;
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin : predict_list_op
            op_type     op;
            int         pos;
            result_type r;
            op  = op_type'(req_ch.opcode);
            pos = req_ch.position;
            r.status             = STATUS_DONE;
            r.data_out           = '0;
            r.appended_when_full = 1'b0;
            if (op == OP_APPEND) begin
               // append needs only room at the tail
               if (list_len >= LIST_DEPTH) begin
                  r.status             = STATUS_FULL;
                  r.appended_when_full = 1'b1;
               end else begin
                  list_words[list_len] = req_ch.item_value;
                  list_len++;
               end
            end else if (pos >= list_len) begin
               // range check wins over the full check
               r.status = STATUS_RANGE;
            end else if (op == OP_INSERT) begin
               if (list_len >= LIST_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  // open a gap at pos: move the tail one place right
                  for (int i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
                  list_words[pos] = req_ch.item_value;
                  list_len++;
               end
            end else begin
               r.data_out = list_words[pos];
               if (op == OP_REMOVE) begin
                  // close the gap: move the tail one place left
                  for (int i = pos + 1; i < list_len; i++) list_words[i - 1] = list_words[i];
                  list_len--;
               end
            end
            r.element_count = list_len[COUNT_W-1:0];
            awaited_results.push_back(r);
         end
      end
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of test.
   // ------------------------------------------------------------------------
   initial begin
      int mode;
      int left_in_mode;
      int roll;
      int w_append;
      int w_insert;
      int w_read;

      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_APPEND;
      req_ch.position   = '0;
      req_ch.item_value = '0;
      rsp_ch.ready      = 1'b0;
      issued_ops        = 0;
      gen_len           = 0;
      list_len          = 0;
      error_count       = 0;
      cycle_count       = 0;

      // Directed: empty-list refusals, field extremes, head and tail edits.
      add_op(OP_READ,   0,  32'h1234_5678);
      add_op(OP_REMOVE, 0,  '1);
      add_op(OP_INSERT, 0,  32'hDEAD_BEEF);
      add_op(OP_READ,   63, '0);
      add_op(OP_APPEND, 63, '0);
      add_op(OP_APPEND, 0,  '1);
      add_op(OP_APPEND, 21, 32'hA5A5_A5A5);
      add_op(OP_INSERT, 0,  32'h5A5A_5A5A);
      add_op(OP_INSERT, 3,  32'h0000_0001);
      add_op(OP_READ,   0,  '0);
      add_op(OP_READ,   4,  '1);
      add_op(OP_READ,   5,  '0);
      add_op(OP_INSERT, 5,  32'h8000_0000);
      add_op(OP_REMOVE, 63, '0);
      add_op(OP_REMOVE, 4,  '0);
      add_op(OP_REMOVE, 0,  '1);
      add_op(OP_INSERT, 63, 32'h7FFF_FFFF);
      add_op(OP_READ,   2,  '0);
      add_op(OP_REMOVE, 2,  '0);
      add_op(OP_READ,   2,  '0);

      // Random: runs of growth (to hit the full store), shrinkage (to drain
      // to empty) and even churn. Open with a long growth run.
      mode         = MODE_GROW;
      left_in_mode = 110;
      for (int k = 0; k < RANDOM_OPS; k++) begin
         if (left_in_mode == 0) begin
            mode         = $urandom_range(MODE_GROW, MODE_MIXED);
            left_in_mode = $urandom_range(30, 90);
         end
         left_in_mode--;
         case (mode)
            MODE_GROW:   begin w_append = 55; w_insert = 80; w_read = 90; end
            MODE_SHRINK: begin w_append = 10; w_insert = 20; w_read = 40; end
            default:     begin w_append = 25; w_insert = 50; w_read = 75; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < w_append) add_op(OP_APPEND, $urandom_range(0, LIST_DEPTH - 1), random_word());
         else if (roll < w_insert) add_op(OP_INSERT, random_pos(), random_word());
         else if (roll < w_read) add_op(OP_READ, random_pos(), random_word());
         else add_op(OP_REMOVE, random_pos(), random_word());
      end
      total_ops = pending_ops.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Hold until every transaction is sent and answered.
      @(posedge clock);
      while (pending_ops.size() > 0 || req_ch.valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ils_pkg.sv
hw/rtl/ils_req_if.sv
hw/rtl/ils_rsp_if.sv
hw/rtl/ils_ram.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
hw/rtl/ils_checker.sv
bench/tb.sv
